>>> sv/frob_pkg.sv
// Shared types and constants for the Frobenius norm accumulator.
// Used by frob_ctrl, frob_datapath and frobenius_norm_accumulator_core.
// Depends on nothing else.
package frob_pkg;

  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned SQ_W    = 31;  // |element|^2 is at most 2^30
  localparam int unsigned NORM_W  = 22;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 7'd5;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 7'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_ROOT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic sq_add;
    logic start_root;
    logic root_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_elem;
    logic root_last;
  } status_t;

endpackage

>>> sv/frob_ctrl.sv
// Controller state machine for the Frobenius norm accumulator.
// Sequences accumulation, the square root iterations and the output register.
// Depends on frob_pkg.
module frob_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  frob_pkg::status_t status_i,
  output frob_pkg::cmd_t    cmd_o
);

  frob_pkg::state_e state_q, state_d;
  logic sq_vld_q, sq_vld_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frob_pkg::ST_ACCUM;
      sq_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sq_vld_q    <= sq_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      frob_pkg::ST_ACCUM: begin
        if (in_valid_i && status_i.last_elem) state_d = frob_pkg::ST_FLUSH;
      end
      frob_pkg::ST_FLUSH: state_d = frob_pkg::ST_ROOT;
      frob_pkg::ST_ROOT: begin
        if (status_i.root_last) state_d = frob_pkg::ST_DONE;
      end
      frob_pkg::ST_DONE: begin
        if (out_free) state_d = frob_pkg::ST_ACCUM;
      end
      default: state_d = frob_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      frob_pkg::ST_ACCUM: begin
        in_stall_o    = 1'b0;
        cmd_o.accept  = in_valid_i;
        cmd_o.sq_add  = sq_vld_q;
      end
      frob_pkg::ST_FLUSH: cmd_o.start_root = 1'b1;
      frob_pkg::ST_ROOT:  cmd_o.root_step  = 1'b1;
      frob_pkg::ST_DONE:  cmd_o.load_out   = out_free;
      default: ;
    endcase
  end

  // The square of a taken word lands in the next cycle and is added then.
  assign sq_vld_d = cmd_o.accept;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/frob_datapath.sv
// Datapath for the Frobenius norm accumulator: config registers, squarer,
// accumulator, element counter, bit-serial square root and output register.
// Depends on frob_pkg.
module frob_datapath #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [frob_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [frob_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic signed [frob_pkg::ELEM_W-1:0]  element_i,
  input  frob_pkg::cmd_t                      cmd_i,
  output frob_pkg::status_t                   status_o,
  output logic [frob_pkg::NORM_W-1:0]         norm_o
);

  localparam int unsigned MAX_ELEMS = MAX_ROWS * MAX_COLS;
  localparam int unsigned CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int unsigned PROD_W    = 2 * frob_pkg::CFG_W;
  localparam int unsigned CMP_W     = (CNT_W > PROD_W) ? CNT_W : PROD_W;
  localparam int unsigned SUM_W     = frob_pkg::SQ_W - 1 + CNT_W;
  localparam int unsigned ROOT_W    = (SUM_W + 1) / 2;
  localparam logic [SUM_W-1:0] BIT_INIT = SUM_W'(1) << (2 * (ROOT_W - 1));
  localparam logic [SUM_W-1:0] NORM_SAT = SUM_W'(frob_pkg::NORM_MAX);

  function automatic logic [frob_pkg::CFG_W-1:0] clamp_count(
    input logic [frob_pkg::CFG_W-1:0] v,
    input int unsigned                maxv
  );
    logic [frob_pkg::CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = frob_pkg::CFG_W'(1);
    end else if (32'(v) > maxv) begin
      r = frob_pkg::CFG_W'(maxv);
    end
    return r;
  endfunction

  logic [frob_pkg::CFG_W-1:0] row_count_q, column_count_q;
  logic [frob_pkg::CFG_W-1:0] rows_c, cols_c;
  logic [PROD_W-1:0]          total;
  logic [CMP_W-1:0]           idx_next;
  logic [CNT_W-1:0]           idx_q, idx_d;

  logic [frob_pkg::ELEM_W-1:0]   mag;
  logic [2*frob_pkg::ELEM_W-1:0] prod;
  logic [frob_pkg::SQ_W-1:0]     sq_q;
  logic [SUM_W-1:0]              sum_q, sum_d, sum_plus;

  logic [SUM_W-1:0] x_q, root_q, bit_q;
  logic [SUM_W:0]   trial;
  logic             take;
  logic [frob_pkg::NORM_W-1:0] norm_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= frob_pkg::ROW_COUNT_RESET;
      column_count_q <= frob_pkg::COLUMN_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        frob_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        frob_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_c   = clamp_count(row_count_q, MAX_ROWS);
  assign cols_c   = clamp_count(column_count_q, MAX_COLS);
  assign total    = rows_c * cols_c;
  assign idx_next = CMP_W'(idx_q) + CMP_W'(1);
  assign status_o.last_elem = (idx_next >= CMP_W'(total));

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.accept) begin
      idx_d = status_o.last_elem ? '0 : idx_next[CNT_W-1:0];
    end
  end

  // The square is registered; it joins the sum in the following cycle.
  assign mag  = element_i[frob_pkg::ELEM_W-1] ? (~element_i + 1'b1) : element_i;
  assign prod = mag * mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) sq_q <= prod[frob_pkg::SQ_W-1:0];
  end

  assign sum_plus = sum_q + SUM_W'(sq_q);

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.start_root) begin
      sum_d = '0;
    end else if (cmd_i.sq_add) begin
      sum_d = sum_plus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
    end
  end

  // Restoring square root, one root bit per step.
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign take  = ({1'b0, x_q} >= trial);
  assign status_o.root_last = bit_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_root) begin
      x_q    <= sum_plus;
      root_q <= '0;
      bit_q  <= BIT_INIT;
    end else if (cmd_i.root_step) begin
      if (take) begin
        x_q    <= x_q - trial[SUM_W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      norm_q <= (root_q > NORM_SAT) ? frob_pkg::NORM_MAX : root_q[frob_pkg::NORM_W-1:0];
    end
  end

  assign norm_o = norm_q;

endmodule

>>> sv/frobenius_norm_accumulator_core.sv
// Frobenius norm accumulator: one signed Q8.8 word per cycle when not stalled, norm in Q14.8.
// After the last word of a matrix is taken, a flush step starts the square root,
// which yields one bit a cycle, and norm_o is registered once the output is free.
// Input is stalled from the last word of a matrix until the norm is loaded.
// Reset (rst_ni low, asynchronous) clears the sum, counter and output valid,
// and sets row_count to 5 and column_count to 8.
module frobenius_norm_accumulator_core #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [frob_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [frob_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [frob_pkg::ELEM_W-1:0]  element_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [frob_pkg::NORM_W-1:0]         norm_o
);

  frob_pkg::cmd_t    cmd;
  frob_pkg::status_t status;

  frob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  frob_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .element_i  (element_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .norm_o     (norm_o)
  );

endmodule

>>> sim/frobenius_norm_accumulator_core_tb.sv
// Self-checking testbench for frobenius_norm_accumulator_core.
// Streams Q8.8 words under random idling and stalls and checks each norm against
// its own running sum-of-squares predictor. Depends on frob_pkg and the core.
module frobenius_norm_accumulator_core_tb;

  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned MAX_COLS    = 64;
  localparam int unsigned RAND_WORDS  = 1950;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Indexes past the register list; writes to them must have no effect.
  localparam logic [frob_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [frob_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 cfg_we_i    = 1'b0;
  logic [frob_pkg::CFG_IDX_W-1:0]       cfg_idx_i   = '0;
  logic [frob_pkg::CFG_W-1:0]           cfg_data_i  = '0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_stall_o;
  logic signed [frob_pkg::ELEM_W-1:0]   element_i   = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic [frob_pkg::NORM_W-1:0]          norm_o;

  logic signed [frob_pkg::ELEM_W-1:0] pending_words[$];
  logic [frob_pkg::NORM_W-1:0]        expected_norms[$];
  logic [frob_pkg::NORM_W-1:0]        norm_head;

  // Predictor state: register copies, running sum and word count.
  logic [frob_pkg::CFG_W-1:0] row_cfg = frob_pkg::ROW_COUNT_RESET;
  logic [frob_pkg::CFG_W-1:0] col_cfg = frob_pkg::COLUMN_COUNT_RESET;
  longint unsigned   square_total = 0;
  int unsigned       words_taken  = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_ack       = 0;
  int unsigned hold_left      = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  frobenius_norm_accumulator_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .element_i  (element_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .norm_o     (norm_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned effective_dim(input logic [frob_pkg::CFG_W-1:0] v,
                                                input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned matrix_words();
    return effective_dim(row_cfg, MAX_ROWS) * effective_dim(col_cfg, MAX_COLS);
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // The end of a matrix is judged against the counts in force at each word.
  function automatic void accumulate_word(input logic signed [frob_pkg::ELEM_W-1:0] w);
    int              v;
    longint unsigned mag;
    longint unsigned root;
    v = w;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    square_total += mag * mag;
    words_taken++;
    if (words_taken >= matrix_words()) begin
      root = floor_root(square_total);
      if (root > frob_pkg::NORM_MAX) root = frob_pkg::NORM_MAX;
      expected_norms.push_back(root[frob_pkg::NORM_W-1:0]);
      square_total = 0;
      words_taken  = 0;
    end
  endfunction

  function automatic logic signed [frob_pkg::ELEM_W-1:0] random_word();
    logic [frob_pkg::ELEM_W-1:0] w;
    case ($urandom_range(7))
      0: w = 16'h8000;
      1: w = 16'h7FFF;
      2: w = 16'($urandom_range(15));
      3: w = 16'(-$urandom_range(15));
      default: w = 16'($urandom());
    endcase
    return w;
  endfunction

  function automatic logic [frob_pkg::CFG_W-1:0] random_dim();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  // Driver: a stalled word is held; otherwise valid is decided without
  // looking at the stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      element_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) accumulate_word(element_i);
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          element_i  <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by a request from the stimulus process.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ack  <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_norms.size() == 0) begin
          $display("%0t: norm with nothing expected, expected none, actual %0d",
                   $time, norm_o);
          error_count++;
        end else begin
          norm_head = expected_norms.pop_front();
          if (norm_o !== norm_head) begin
            $display("%0t: norm mismatch, expected %0d, actual %0d",
                     $time, norm_head, norm_o);
            error_count++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [frob_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frob_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == frob_pkg::CFG_ROW_COUNT) row_cfg = val;
    else if (idx == frob_pkg::CFG_COLUMN_COUNT) col_cfg = val;
    @(negedge clk_i);
  endtask

  // Waits until every word is taken and every norm has come, then lets a
  // root still in flight from a partial matrix settle.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_norms.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 63 : (mode == IDLE_BOTH) ? 26 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 63 : (mode == IDLE_BOTH) ? 26 : 0;
  endtask

  initial begin
    int unsigned                rand_words;
    int unsigned                phase;
    int unsigned                total;
    int unsigned                max_mats;
    int unsigned                n_words;
    logic [frob_pkg::CFG_W-1:0] rows;
    logic [frob_pkg::CFG_W-1:0] cols;

    rand_words = 0;
    phase = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a partial matrix at the reset counts, then the counts shrink
    // below the words already taken so the next word closes the matrix.
    set_idling(IDLE_NONE);
    pending_words.push_back(16'h8000);
    pending_words.push_back(16'h7FFF);
    pending_words.push_back(16'h0000);
    wait_idle();
    write_reg(frob_pkg::CFG_ROW_COUNT, 7'd0);
    write_reg(frob_pkg::CFG_COLUMN_COUNT, 7'd1);
    pending_words.push_back(16'hFFFF);
    pending_words.push_back(16'h0001);
    pending_words.push_back(16'h8000);
    pending_words.push_back(16'h7FFF);
    pending_words.push_back(16'h0100);
    pending_words.push_back(16'h8001);
    pending_words.push_back(16'h5555);
    pending_words.push_back(16'hAAAA);
    wait_idle();
    write_reg(CFG_IDX_SPARE_A, 7'h7F);
    write_reg(CFG_IDX_SPARE_B, 7'h7F);
    write_reg(frob_pkg::CFG_ROW_COUNT, 7'd2);
    write_reg(frob_pkg::CFG_COLUMN_COUNT, 7'd2);
    repeat (4) pending_words.push_back(16'h8000);
    repeat (4) pending_words.push_back(16'h7FFF);
    pending_words.push_back(16'h0000);
    wait_idle();

    while (rand_words < RAND_WORDS || phase < 12) begin
      case (phase)
        1: begin rows = 7'd127; cols = 7'd1; end
        2: begin rows = 7'd1;   cols = 7'd1; end
        3: begin rows = 7'd1;   cols = 7'd127; end
        5: begin rows = 7'd0;   cols = 7'd0; end
        7: begin rows = 7'd32;  cols = 7'd32; end
        default: begin
          rows = random_dim();
          cols = random_dim();
          if (effective_dim(rows, MAX_ROWS) * effective_dim(cols, MAX_COLS) > 128)
            cols = 7'($urandom_range(0, 2));
        end
      endcase
      write_reg(frob_pkg::CFG_ROW_COUNT, rows);
      write_reg(frob_pkg::CFG_COLUMN_COUNT, cols);
      if ($urandom_range(7) == 0)
        write_reg(2'(CFG_IDX_SPARE_A + $urandom_range(1)), 7'($urandom()));
      set_idling(idle_mode_e'(phase % 4));
      total = matrix_words();

      if (phase == 7) begin
        // A large matrix of the most negative word drives the sum far up.
        repeat (total) pending_words.push_back(16'h8000);
        rand_words += total;
      end else begin
        if (phase == 2) begin
          // Receiver holds off while single-word matrices keep arriving.
          set_idling(IDLE_NONE);
          hold_req++;
          n_words = 40;
        end else begin
          max_mats = (total >= 120) ? 1 : 120 / total;
          n_words  = total * $urandom_range(1, max_mats);
          if ($urandom_range(1)) n_words += $urandom_range(0, total - 1);
        end
        repeat (n_words) pending_words.push_back(random_word());
        rand_words += n_words;
      end
      wait_idle();
      phase++;
    end

    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
sv/frob_pkg.sv
sv/frob_ctrl.sv
sv/frob_datapath.sv
sv/frobenius_norm_accumulator_core.sv
sim/frobenius_norm_accumulator_core_tb.sv
